### hw/rtl/sorted_list_insert_readout_defines.svh
// ----------------------------------------------------------------------------
// Sorted list assertion macros
// Concurrent assertion shorthands clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_READOUT_DEFINES_SVH
`define SORTED_LIST_INSERT_READOUT_DEFINES_SVH

// check outside reset
`define SLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check at every edge, reset included
`define SLI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/sli_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list package
// Shared types and constants of the sorted insertion list.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int unsigned ValueW           = 32;
  localparam int unsigned ListDepthDefault = 16;

  typedef enum logic [1:0] {
    FUNC_INSERT   = 2'd0,
    FUNC_READ_ASC = 2'd1,
    FUNC_READ_DSC = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  typedef struct packed {
    logic ins;
    logic rot;
  } cell_ctrl_t;

endpackage

### hw/rtl/sli_cell.sv
// ----------------------------------------------------------------------------
// Sorted list cell
// Holds one entry; keeps it, takes the new value or the lower neighbour's
// entry on insert, and takes the rotation value on readout.
// ----------------------------------------------------------------------------
module sli_cell import sli_pkg::*; (
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic                     occupied_i,
  input  logic signed [ValueW-1:0] ins_value_i,
  input  logic signed [ValueW-1:0] prev_value_i,
  input  logic                     prev_less_i,
  input  logic signed [ValueW-1:0] rot_value_i,
  output logic signed [ValueW-1:0] value_o,
  output logic                     less_o
);

  logic signed [ValueW-1:0] value_q, value_d;

  assign less_o  = occupied_i && (value_q < ins_value_i);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins) begin
      if (less_o) begin
        value_d = value_q;
      end else if (prev_less_i) begin
        value_d = ins_value_i;
      end else begin
        value_d = prev_value_i;
      end
    end else if (ctrl_i.rot) begin
      value_d = rot_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

### hw/rtl/sorted_list_insert_readout.sv
// Insert or empty read: the result is registered, valid next cycle.
// Read of n entries: the first result passes through ST_READ and the output
// register, then one per cycle while out_ready_i is high; input is taken again
// with the final transfer.
// Reset (rst_ni low, asynchronous) empties the list and drops any pending
// result; entry values are not cleared.
// ----------------------------------------------------------------------------
// Sorted insertion list
// Chain of cells keeping signed values in ascending order, with insert and
// full readout in either direction.
// ----------------------------------------------------------------------------
`include "sorted_list_insert_readout_defines.svh"

module sorted_list_insert_readout import sli_pkg::*; #(
  parameter int unsigned LIST_DEPTH = ListDepthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               func_i,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [ValueW-1:0] out_value_o,
  output logic [1:0]               status_o,
  output logic                     last_o
);

  localparam int unsigned IdxW = $clog2(LIST_DEPTH);
  localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);
  localparam logic [CntW-1:0] Depth = CntW'(LIST_DEPTH);

  state_e                   state_q, state_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [CntW-1:0]          rd_cnt_q, rd_cnt_d;
  logic                     dsc_q, dsc_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [ValueW-1:0] out_value_q, out_value_d;
  status_e                  status_q, status_d;
  logic                     last_q, last_d;

  cell_ctrl_t               ctrl;
  logic                     out_free, in_xfer, full;
  logic [CntW-1:0]          tail_cnt;
  logic [IdxW-1:0]          tail_idx;
  logic signed [ValueW-1:0] tail_value, tap_value;
  logic signed [ValueW-1:0] cell_value [LIST_DEPTH];
  logic                     cell_less  [LIST_DEPTH];

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign full       = (count_q == Depth);
  assign tail_cnt   = count_q - 1'b1;
  assign tail_idx   = tail_cnt[IdxW-1:0];
  assign tail_value = cell_value[tail_idx];
  assign tap_value  = dsc_q ? tail_value : cell_value[0];

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic signed [ValueW-1:0] prev_value, up_value, rot_value;
    logic                     prev_less, is_tail;

    assign is_tail = (tail_idx == IdxW'(i));

    if (i == 0) begin : g_head
      assign prev_value = value_i;
      assign prev_less  = 1'b1;
      assign rot_value  = dsc_q ? tail_value : (is_tail ? cell_value[0] : up_value);
    end else begin : g_body
      assign prev_value = cell_value[i-1];
      assign prev_less  = cell_less[i-1];
      assign rot_value  = dsc_q ? cell_value[i-1] : (is_tail ? cell_value[0] : up_value);
    end

    if (i == LIST_DEPTH - 1) begin : g_last
      assign up_value = cell_value[0];
    end else begin : g_up
      assign up_value = cell_value[i+1];
    end

    sli_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (CntW'(i) < count_q),
      .ins_value_i  (value_i),
      .prev_value_i (prev_value),
      .prev_less_i  (prev_less),
      .rot_value_i  (rot_value),
      .value_o      (cell_value[i]),
      .less_o       (cell_less[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_cnt_d    = rd_cnt_q;
    dsc_d       = dsc_q;
    out_value_d = out_value_q;
    status_d    = status_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ctrl        = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (func_e'(func_i))
            FUNC_INSERT: begin
              out_valid_d = 1'b1;
              out_value_d = value_i;
              last_d      = 1'b1;
              if (full) begin
                status_d = STATUS_FULL;
              end else begin
                status_d = STATUS_OK;
                ctrl.ins = 1'b1;
                count_d  = count_q + 1'b1;
              end
            end
            FUNC_READ_ASC, FUNC_READ_DSC: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                out_value_d = '0;
                status_d    = STATUS_EMPTY;
                last_d      = 1'b1;
              end else begin
                state_d  = ST_READ;
                rd_cnt_d = count_q;
                dsc_d    = (func_e'(func_i) == FUNC_READ_DSC);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = tap_value;
          status_d    = STATUS_OK;
          last_d      = (rd_cnt_q == CntW'(1));
          ctrl.rot    = 1'b1;
          rd_cnt_d    = rd_cnt_q - 1'b1;
          if (rd_cnt_q == CntW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_cnt_q    <= '0;
      dsc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_cnt_q    <= rd_cnt_d;
      dsc_q       <= dsc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    status_q    <= status_d;
    last_q      <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

  `SLI_ASSERT_ALWAYS(a_count_bound, count_q <= Depth, "fill count beyond list depth")
  `SLI_ASSERT(a_read_cnt, (state_q == ST_READ) |-> (rd_cnt_q != '0 && rd_cnt_q <= count_q), "read counter out of range")
  `SLI_ASSERT(a_no_take_in_read, (state_q == ST_READ) |-> !in_ready_o, "input taken during readout")
  `SLI_ASSERT(a_insert_grows, (in_xfer && func_i == FUNC_INSERT && !full) |=> (count_q == $past(count_q) + 1'b1), "insert did not grow the list")
  `SLI_ASSERT(a_read_keeps, (state_q == ST_READ) |=> (count_q == $past(count_q)), "list size changed during readout")

endmodule
